// ===== design/boyer_moore_shift_tables_assert.svh =====
// assertion macros for the shift table block
`ifndef BOYER_MOORE_SHIFT_TABLES_ASSERT_SVH
`define BOYER_MOORE_SHIFT_TABLES_ASSERT_SVH

`ifndef SYNTHESIS
`define BMST_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define BMST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMST_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define BMST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/bmst_pkg.sv =====
package bmst_pkg;

  localparam int MAX_PATTERN_DEF   = 64;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int SYMBOL_W          = 8;
  localparam int POSITION_W        = 6;
  localparam int OP_W              = 2;
  localparam int VALUE_W           = 17;
  localparam int BONUS_W           = 16;
  localparam logic [BONUS_W-1:0] BONUS_RESET = 16'd1024;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SKIP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SHIFT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic lk_issue;
    logic lk_shift;
    logic out_load;
    logic fill_start;
    logic fill_step;
    logic pass_start;
    logic pass_rd;
    logic pass_ls;
    logic pass_wr;
    logic sf_start;
    logic sf_edge_wr;
    logic sf_init_rd;
    logic sf_d_set;
    logic sf_wr;
    logic sf_cmp_rd;
    logic sf_cmp;
    logic set_ready;
  } bmst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic pass_end;
    logic sf_j_done;
    logic sf_k_end;
    logic sf_end;
  } bmst_sts_t;

endpackage

// ===== design/bmst_ctrl.sv =====
module bmst_ctrl
  import bmst_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_op,
  input  logic            in_last,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  bmst_sts_t       sts,
  output bmst_cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOOK   = 4'd1;
  localparam logic [3:0] ST_FILL   = 4'd2;
  localparam logic [3:0] ST_PASS_A = 4'd3;
  localparam logic [3:0] ST_PASS_B = 4'd4;
  localparam logic [3:0] ST_PASS_C = 4'd5;
  localparam logic [3:0] ST_SF_A   = 4'd6;
  localparam logic [3:0] ST_SF_B   = 4'd7;
  localparam logic [3:0] ST_SF_C   = 4'd8;
  localparam logic [3:0] ST_SF_D   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_LOAD: begin
              cmd.load = 1'b1;
              if (in_last) begin
                cmd.fill_start = 1'b1;
                state_nxt      = ST_FILL;
              end
            end
            OP_SKIP, OP_SHIFT: begin
              cmd.lk_issue = 1'b1;
              cmd.lk_shift = (in_op == OP_SHIFT);
              state_nxt    = ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.pass_start = 1'b1;
          state_nxt      = ST_PASS_A;
        end
      end
      ST_PASS_A: begin
        if (sts.pass_end) begin
          cmd.sf_start = 1'b1;
          state_nxt    = ST_SF_A;
        end else begin
          cmd.pass_rd = 1'b1;
          state_nxt   = ST_PASS_B;
        end
      end
      ST_PASS_B: begin
        cmd.pass_ls = 1'b1;
        state_nxt   = ST_PASS_C;
      end
      ST_PASS_C: begin
        cmd.pass_wr = 1'b1;
        state_nxt   = ST_PASS_A;
      end
      ST_SF_A: begin
        if (sts.sf_j_done) begin
          cmd.set_ready = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.sf_k_end) begin
          cmd.sf_edge_wr = 1'b1;
        end else begin
          cmd.sf_init_rd = 1'b1;
          state_nxt      = ST_SF_B;
        end
      end
      ST_SF_B: begin
        cmd.sf_d_set = 1'b1;
        state_nxt    = ST_SF_C;
      end
      ST_SF_C: begin
        if (sts.sf_end) begin
          cmd.sf_wr = 1'b1;
          state_nxt = ST_SF_A;
        end else begin
          cmd.sf_cmp_rd = 1'b1;
          state_nxt     = ST_SF_D;
        end
      end
      ST_SF_D: begin
        cmd.sf_cmp = 1'b1;
        state_nxt  = ST_SF_C;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/bmst_dp.sv =====
module bmst_dp
  import bmst_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [BONUS_W-1:0]    cfg_wr_data,
  input  logic [SYMBOL_W-1:0]   in_symbol,
  input  logic [POSITION_W-1:0] in_position,
  input  bmst_cmd_t             cmd,
  output bmst_sts_t             sts,
  output logic [VALUE_W-1:0]    out_value,
  output logic                  out_error
);

  localparam int CW  = $clog2(MAX_PATTERN + 1);
  localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW  = $clog2(ALPHABET_SIZE);
  localparam int DW  = CW + 2;
  localparam int IW  = CW + 1;
  localparam int PXW = (AW > POSITION_W) ? AW : POSITION_W;

  logic [BONUS_W-1:0] bonus_r;
  logic [CW-1:0]      cnt_r;
  logic               ready_r;
  logic [SW-1:0]      fill_r;
  logic [CW-1:0]      pi_r;
  logic [CW-1:0]      sj_r;
  logic [IW-1:0]      si_r;
  logic signed [DW-1:0] sd_r;
  logic               lk_err_r, lk_sel_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_error_r;

  logic [SW-1:0]      pat_mem [MAX_PATTERN];
  logic [VALUE_W-1:0] skip_mem [ALPHABET_SIZE];
  logic [CW-1:0]      ls_mem [ALPHABET_SIZE];
  logic [CW-1:0]      rd_mem [MAX_PATTERN];
  logic [CW:0]        sh_mem [MAX_PATTERN];
  logic [SW-1:0]      pa_q, pb_q;
  logic [VALUE_W-1:0] skip_q;
  logic [CW-1:0]      ls_q, rd_q;
  logic [CW:0]        sh_q;

  logic [CW-1:0]        n, cnt_eff;
  logic [IW-1:0]        kk;
  logic [CW+1:0]        k_plus_i;
  logic signed [DW:0]   d_plus_i;
  logic [SW-1:0]        sym_clamp;
  logic [PXW-1:0]       pos_x;
  logic [AW-1:0]        pat_a_addr, rd_addr;
  logic [VALUE_W-1:0]   skip_wr;
  logic [CW-1:0]        rd_wr;
  logic signed [DW-1:0] n_minus_d, neg_d;
  logic                 mism, lk_err;

  assign n         = cnt_r;
  assign cnt_eff   = ready_r ? '0 : cnt_r;
  assign kk        = IW'(sj_r) + IW'(1);
  assign k_plus_i  = (CW+2)'(kk) + (CW+2)'(si_r);
  assign d_plus_i  = $signed({sd_r[DW-1], sd_r}) + $signed({2'b00, si_r});
  assign sym_clamp = (32'(in_symbol) >= 32'(ALPHABET_SIZE)) ? SW'(ALPHABET_SIZE - 1)
                                                            : in_symbol[SW-1:0];
  assign pos_x     = PXW'(in_position);
  assign n_minus_d = $signed({2'b00, n}) - sd_r;
  assign neg_d     = DW'(0) - sd_r;
  assign mism      = !d_plus_i[DW] && (pa_q != pb_q);
  assign rd_wr     = CW'(IW'(pi_r) + IW'(1) - IW'(ls_q));
  assign skip_wr   = VALUE_W'(n) - VALUE_W'(pi_r) - VALUE_W'(1)
                   + ((pi_r == CW'(n - CW'(1))) ? VALUE_W'(bonus_r) : '0);
  assign pat_a_addr = cmd.pass_rd ? pi_r[AW-1:0] : d_plus_i[AW-1:0];
  assign rd_addr    = cmd.sf_init_rd ? kk[AW-1:0] : sd_r[AW-1:0];

  always_comb begin
    if (cmd.lk_shift) begin
      lk_err = !ready_r || (32'(in_position) >= 32'(cnt_r));
    end else begin
      lk_err = !ready_r || (32'(in_symbol) >= 32'(ALPHABET_SIZE));
    end
  end

  assign sts.fill_last = (fill_r == SW'(ALPHABET_SIZE - 1));
  assign sts.pass_end  = (pi_r == n);
  assign sts.sf_j_done = (sj_r == n);
  assign sts.sf_k_end  = (kk >= IW'(n));
  assign sts.sf_end    = (k_plus_i >= (CW+2)'(n));

  assign out_value = out_value_r;
  assign out_error = out_error_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bonus_r <= BONUS_RESET;
      cnt_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bonus_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        ready_r <= 1'b0;
        if (cnt_eff < CW'(MAX_PATTERN)) begin
          cnt_r <= cnt_eff + CW'(1);
        end else begin
          cnt_r <= cnt_eff;
        end
      end
      if (cmd.set_ready) begin
        ready_r <= 1'b1;
      end
    end
  end

  // build counters and lookup capture
  always_ff @(posedge clk) begin
    if (cmd.fill_start) fill_r <= '0;
    else if (cmd.fill_step) fill_r <= fill_r + SW'(1);
    if (cmd.pass_start) pi_r <= '0;
    else if (cmd.pass_wr) pi_r <= pi_r + CW'(1);
    if (cmd.sf_start) sj_r <= '0;
    else if (cmd.sf_edge_wr || cmd.sf_wr) sj_r <= sj_r + CW'(1);
    if (cmd.sf_d_set) begin
      sd_r <= $signed({1'b0, kk}) - $signed({2'b00, rd_q});
      si_r <= '0;
    end else if (cmd.sf_cmp) begin
      if (mism) begin
        if (sd_r[DW-1]) begin
          si_r <= neg_d[IW-1:0] + IW'(1);
          sd_r <= sd_r - DW'(1);
        end else begin
          si_r <= IW'(1);
          sd_r <= sd_r - $signed({2'b00, rd_q});
        end
      end else begin
        si_r <= si_r + IW'(1);
      end
    end
    if (cmd.lk_issue) begin
      lk_err_r <= lk_err;
      lk_sel_r <= cmd.lk_shift;
    end
    if (cmd.out_load) begin
      out_error_r <= lk_err_r;
      if (lk_err_r) out_value_r <= '0;
      else if (lk_sel_r) out_value_r <= VALUE_W'(sh_q);
      else out_value_r <= skip_q;
    end
  end

  // pattern store, two read ports
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_eff < CW'(MAX_PATTERN))) begin
      pat_mem[cnt_eff[AW-1:0]] <= sym_clamp;
    end
    if (cmd.pass_rd || cmd.sf_cmp_rd) pa_q <= pat_mem[pat_a_addr];
    if (cmd.sf_cmp_rd) pb_q <= pat_mem[k_plus_i[AW-1:0]];
  end

  // bad-character skip table
  always_ff @(posedge clk) begin
    if (cmd.fill_step) skip_mem[fill_r] <= VALUE_W'(n);
    else if (cmd.pass_wr) skip_mem[pa_q] <= skip_wr;
    if (cmd.lk_issue) skip_q <= skip_mem[in_symbol[SW-1:0]];
  end

  // last seen position per symbol
  always_ff @(posedge clk) begin
    if (cmd.fill_step) ls_mem[fill_r] <= '0;
    else if (cmd.pass_wr) ls_mem[pa_q] <= CW'(pi_r + CW'(1));
    if (cmd.pass_ls) ls_q <= ls_mem[pa_q];
  end

  // distance to previous occurrence
  always_ff @(posedge clk) begin
    if (cmd.pass_wr) rd_mem[pi_r[AW-1:0]] <= rd_wr;
    if (cmd.sf_init_rd || cmd.sf_cmp_rd) rd_q <= rd_mem[rd_addr];
  end

  // good-suffix shift table
  always_ff @(posedge clk) begin
    if (cmd.sf_edge_wr) sh_mem[sj_r[AW-1:0]] <= (CW+1)'(n) - (CW+1)'(sj_r);
    else if (cmd.sf_wr) sh_mem[sj_r[AW-1:0]] <= n_minus_d[CW:0];
    if (cmd.lk_issue) sh_q <= sh_mem[pos_x[AW-1:0]];
  end

endmodule

// ===== design/boyer_moore_shift_tables.sv =====
// Boyer-Moore skip and shift tables. The pattern comes in one symbol per
// transaction (tuser = load) and the transaction with tlast set starts the
// table build; lookups (tuser = skip or shift) each return one result with an
// error flag in tuser, a load returns nothing. A load that is not the last
// leaves the block idle and ready. A lookup holds the input side from
// acceptance until its result is taken: the table read is registered, then
// the result goes into the output register. The build is a sequencer over the
// datapath memories: a sweep of the skip and last-seen tables over all
// ALPHABET_SIZE symbols, an occurrence pass over every pattern symbol, then
// for every position of the good-suffix search a set-up plus compare steps,
// whose number for an n-symbol pattern grows up to about n squared. No
// transaction is accepted while the build runs; the large bonus register may
// be written at any time the block is idle and is sampled during the build.
module boyer_moore_shift_tables
  import bmst_pkg::*;
#(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: large bonus
  input  logic               cfg_wr_en,
  input  logic [BONUS_W-1:0] cfg_wr_data,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // symbol[7:0], position[13:8], zeros
  input  logic               in_tlast,   // last pattern symbol
  input  logic [OP_W-1:0]    in_tuser,   // op
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // table_value[16:0], zeros
  output logic               out_tuser   // lookup_error
);

  `include "boyer_moore_shift_tables_assert.svh"

  bmst_cmd_t          cmd;
  bmst_sts_t          sts;
  logic [VALUE_W-1:0] value;
  logic               err;

  // sequencer: handshakes and build steps
  bmst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // memories, counters and the output register
  bmst_dp #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_symbol   (in_tdata[SYMBOL_W-1:0]),
    .in_position (in_tdata[SYMBOL_W +: POSITION_W]),
    .cmd         (cmd),
    .sts         (sts),
    .out_value   (value),
    .out_error   (err)
  );

  assign out_tdata = {(24 - VALUE_W)'(0), value};
  assign out_tuser = err;

  // a waiting result blocks new transactions
  `BMST_ASSERT_SAME(a_ready_no_pending, clk, rst_n, in_tready, !out_tvalid, "ready with result pending")
  // an errored lookup reads as zero
  `BMST_ASSERT_SAME(a_err_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 24'd0, "error value not zero")
  // a lookup holds the input side for its read cycle
  `BMST_ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == OP_SKIP || in_tuser == OP_SHIFT), !in_tready, "ready during lookup read")

endmodule
